FILE: rtl/bounded_double_ended_queue_assert.svh
// Assertion macros used by the checker file.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/bdeq_pkg.sv
package bdeq_pkg;

	localparam int DEPTH  = 256;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int WORD_W = 32;

	localparam logic [CNT_W-1:0]  CAP_MAX    = CNT_W'(DEPTH);
	localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

	typedef enum logic [2:0] {
		OP_QUERY      = 3'd0,
		OP_INS_FRONT  = 3'd1,
		OP_INS_REAR   = 3'd2,
		OP_REM_FRONT  = 3'd3,
		OP_REM_REAR   = 3'd4
	} op_t;

endpackage

FILE: rtl/bdeq_ram.sv
// One write port, two read ports, registered read data.
module bdeq_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	localparam int WORDS = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-before-write on a shared address; caller forwards
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: rtl/bounded_double_ended_queue.sv
// A result strobes on done in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, the entry RAM has one write
//   and two read ports, so every step reads it, and an insert also writes it, in the same cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (arst_n low, async): queue empty, front index zero, capacity 256.
//   Entry RAM is not cleared; only written entries are ever read back.
module bounded_double_ended_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          opcode,
	input  logic signed [bdeq_pkg::WORD_W-1:0]  value,
	// result strobe
	output logic                                done,
	output logic                                ok,
	output logic signed [bdeq_pkg::WORD_W-1:0]  front_value,
	output logic signed [bdeq_pkg::WORD_W-1:0]  rear_value,
	output logic                                is_empty,
	output logic                                is_full,
	output logic [bdeq_pkg::CNT_W-1:0]          entry_count,
	// capacity register write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bdeq_pkg::CNT_W-1:0]          capacity
);

	localparam int IDX_W  = bdeq_pkg::IDX_W;
	localparam int CNT_W  = bdeq_pkg::CNT_W;
	localparam int WORD_W = bdeq_pkg::WORD_W;

	// Architectural state: ring front index, count of held entries, capacity.
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_q;

	// Step decode (all combinational from the current state).
	logic             accept;
	logic [CNT_W-1:0] eff_cap;
	logic             full_now;
	logic             step_ok;
	logic [IDX_W-1:0] front_nx;
	logic [CNT_W-1:0] count_nx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_front_addr;
	logic [IDX_W-1:0] rd_rear_addr;

	// Result stage.
	logic              done_s1;
	logic              ok_s1;
	logic              full_s1;
	logic [CNT_W-1:0]  count_s1;
	logic [WORD_W-1:0] value_s1;
	logic              fwd_front_s1;
	logic              fwd_rear_s1;
	logic [WORD_W-1:0] ram_front;
	logic [WORD_W-1:0] ram_rear;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// capacity beyond the ring depth saturates
	assign eff_cap  = (cap_q > bdeq_pkg::CAP_MAX) ? bdeq_pkg::CAP_MAX : cap_q;
	assign full_now = count_q >= eff_cap;

	always_comb begin
		step_ok  = 1'b0;
		front_nx = front_q;
		count_nx = count_q;
		wr_en    = 1'b0;
		wr_addr  = front_q;
		case (bdeq_pkg::op_t'(opcode))
			bdeq_pkg::OP_QUERY: begin
				step_ok = 1'b1;
			end
			bdeq_pkg::OP_INS_FRONT: begin
				if (!full_now) begin
					step_ok  = 1'b1;
					front_nx = front_q - IDX_W'(1);
					count_nx = count_q + CNT_W'(1);
					wr_en    = 1'b1;
					wr_addr  = front_q - IDX_W'(1);
				end
			end
			bdeq_pkg::OP_INS_REAR: begin
				if (!full_now) begin
					step_ok  = 1'b1;
					count_nx = count_q + CNT_W'(1);
					wr_en    = 1'b1;
					// slot just past the old rear
					wr_addr  = front_q + count_q[IDX_W-1:0];
				end
			end
			bdeq_pkg::OP_REM_FRONT: begin
				if (count_q != '0) begin
					step_ok  = 1'b1;
					front_nx = front_q + IDX_W'(1);
					count_nx = count_q - CNT_W'(1);
				end
			end
			bdeq_pkg::OP_REM_REAR: begin
				if (count_q != '0) begin
					step_ok  = 1'b1;
					count_nx = count_q - CNT_W'(1);
				end
			end
			default: begin
				// unused opcode: nothing changes, ok stays low
			end
		endcase
	end

	// Ends after the step. When empty these are don't-care; outputs show -1.
	assign rd_front_addr = front_nx;
	assign rd_rear_addr  = IDX_W'({1'b0, front_nx} + count_nx - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			cap_q   <= bdeq_pkg::CAP_MAX;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				front_q <= front_nx;
				count_q <= count_nx;
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity;
			end
		end
	end

	// Payload of the result stage. The RAM returns pre-write data when the
	// written slot is also read, so the inserted word is forwarded.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1        <= step_ok;
			full_s1      <= count_nx >= eff_cap;
			count_s1     <= count_nx;
			value_s1     <= value;
			fwd_front_s1 <= wr_en && (wr_addr == rd_front_addr);
			fwd_rear_s1  <= wr_en && (wr_addr == rd_rear_addr);
		end
	end

	bdeq_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (WORD_W)
	) u_ram (
		.clk     (clk),
		.we      (accept && wr_en),
		.waddr   (wr_addr),
		.wdata   (value),
		.re      (accept),
		.raddr_a (rd_front_addr),
		.raddr_b (rd_rear_addr),
		.rdata_a (ram_front),
		.rdata_b (ram_rear)
	);

	assign done        = done_s1;
	assign ok          = ok_s1;
	assign is_empty    = count_s1 == '0;
	assign is_full     = full_s1;
	assign entry_count = count_s1;

	always_comb begin
		if (count_s1 == '0) begin
			front_value = bdeq_pkg::EMPTY_WORD;
			rear_value  = bdeq_pkg::EMPTY_WORD;
		end else begin
			front_value = fwd_front_s1 ? value_s1 : ram_front;
			rear_value  = fwd_rear_s1  ? value_s1 : ram_rear;
		end
	end

endmodule

FILE: rtl/bdeq_checker.sv
`include "bounded_double_ended_queue_assert.svh"

module bdeq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [2:0]                          opcode,
	input logic signed [bdeq_pkg::WORD_W-1:0]  value,
	input logic                                done,
	input logic                                ok,
	input logic signed [bdeq_pkg::WORD_W-1:0]  front_value,
	input logic signed [bdeq_pkg::WORD_W-1:0]  rear_value,
	input logic                                is_empty,
	input logic                                is_full,
	input logic [bdeq_pkg::CNT_W-1:0]          entry_count
);

	// every transfer in gives one result strobe the next cycle
	`ASSERT_NEXT(a_result_follows, start && !busy, done)

	// an empty queue reports -1 at both ends and a zero count
	`ASSERT_NOW(a_empty_ends, done && is_empty,
		front_value == bdeq_pkg::EMPTY_WORD && rear_value == bdeq_pkg::EMPTY_WORD
		&& entry_count == '0)

	// count never exceeds the ring depth
	`ASSERT_NOW(a_count_bound, done, entry_count <= bdeq_pkg::CAP_MAX)

	// a successful front insert shows the inserted word at the front
	`ASSERT_NEXT(a_ins_front, start && !busy && opcode == bdeq_pkg::OP_INS_FRONT,
		!ok || front_value == $past(value))

	// a successful rear insert shows the inserted word at the rear
	`ASSERT_NEXT(a_ins_rear, start && !busy && opcode == bdeq_pkg::OP_INS_REAR,
		!ok || rear_value == $past(value))

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (.*);

FILE: verif/bounded_double_ended_queue_tb.sv
`timescale 1ns / 100ps

// One result as the block reports it; field order follows the result ports.
typedef struct packed {
	logic                        ok;
	logic [bdeq_pkg::WORD_W-1:0] front;
	logic [bdeq_pkg::WORD_W-1:0] rear;
	logic                        empty;
	logic                        full;
	logic [bdeq_pkg::CNT_W-1:0]  count;
} deque_status_t;

class deque_scoreboard;
	logic [bdeq_pkg::WORD_W-1:0] slots [bdeq_pkg::DEPTH];
	logic [bdeq_pkg::IDX_W-1:0]  head;
	logic [bdeq_pkg::CNT_W-1:0]  held;
	logic [bdeq_pkg::CNT_W-1:0]  cap_reg;
	deque_status_t               expected_status [$];
	int unsigned       commands, refused, cap_writes, peak_held, mismatches, strays;

	function new();
		head       = '0;
		held       = '0;
		cap_reg    = bdeq_pkg::CAP_MAX;
		commands   = 0;
		refused    = 0;
		cap_writes = 0;
		peak_held  = 0;
		mismatches = 0;
		strays     = 0;
	endfunction

	function logic [bdeq_pkg::IDX_W-1:0] tail_slot();
		return head + held[bdeq_pkg::IDX_W-1:0] - 1'b1;
	endfunction

	function void write_capacity(input logic [bdeq_pkg::CNT_W-1:0] cap);
		cap_reg = cap;
		cap_writes++;
	endfunction

	// Apply one command to the shadow deque and queue up the status it leaves.
	function void take_command(input logic [2:0] op,
		input logic [bdeq_pkg::WORD_W-1:0] word);
		logic [bdeq_pkg::CNT_W-1:0] limit;
		logic                       at_limit;
		deque_status_t              want;
		limit    = (cap_reg > bdeq_pkg::CAP_MAX) ? bdeq_pkg::CAP_MAX : cap_reg;
		at_limit = held >= limit;
		want.ok  = 1'b0;
		case (op)
			bdeq_pkg::OP_QUERY: want.ok = 1'b1;
			bdeq_pkg::OP_INS_FRONT: if (!at_limit) begin
				head        = head - 1'b1;
				slots[head] = word;
				held++;
				want.ok = 1'b1;
			end
			bdeq_pkg::OP_INS_REAR: if (!at_limit) begin
				held++;
				slots[tail_slot()] = word;
				want.ok = 1'b1;
			end
			bdeq_pkg::OP_REM_FRONT: if (held != 0) begin
				head++;
				held--;
				want.ok = 1'b1;
			end
			bdeq_pkg::OP_REM_REAR: if (held != 0) begin
				held--;
				want.ok = 1'b1;
			end
			default: ;
		endcase
		want.empty = (held == 0);
		want.front = want.empty ? bdeq_pkg::EMPTY_WORD : slots[head];
		want.rear  = want.empty ? bdeq_pkg::EMPTY_WORD : slots[tail_slot()];
		want.full  = held >= limit;
		want.count = held;
		expected_status.push_back(want);
		commands++;
		if (!want.ok)
			refused++;
		if (held > peak_held)
			peak_held = 32'(held);
	endfunction

	function void check_result(input deque_status_t got);
		deque_status_t want;
		if (expected_status.size() == 0) begin
			strays++;
			if (mismatches + strays <= 10)
				$display("%0t: result with nothing outstanding, count %0d", $time, got.count);
			return;
		end
		want = expected_status.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches + strays <= 10)
				$display("%0t: exp/act ok %0b/%0b front %h/%h rear %h/%h empty %0b/%0b %s %0d/%0d",
					$time, want.ok, got.ok, want.front, got.front, want.rear, got.rear,
					want.empty, got.empty,
					$sformatf("full %0b/%0b count", want.full, got.full),
					want.count, got.count);
		end
	endfunction
endclass

module bounded_double_ended_queue_tb;

	// Opcodes past the last real one; the block must refuse them.
	localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
	localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
	// Cycles with no transfer of any kind before the run is declared hung.
	localparam int unsigned STALL_LIMIT  = 200;
	localparam int          N_PHASES     = 8;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [2:0]                         opcode;
	logic signed [bdeq_pkg::WORD_W-1:0] value;
	logic                               done;
	logic                               ok;
	logic signed [bdeq_pkg::WORD_W-1:0] front_value;
	logic signed [bdeq_pkg::WORD_W-1:0] rear_value;
	logic                               is_empty;
	logic                               is_full;
	logic [bdeq_pkg::CNT_W-1:0]         entry_count;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [bdeq_pkg::CNT_W-1:0]         capacity;

	deque_scoreboard deque_sb = new();
	int unsigned     quiet_cycles = 0;

	bounded_double_ended_queue i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.value       (value),
		.done        (done),
		.ok          (ok),
		.front_value (front_value),
		.rear_value  (rear_value),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.entry_count (entry_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.capacity    (capacity)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: everything is sampled at the edge, before the block's flops
	// update, so a transfer is seen exactly as the block takes it. The result
	// check runs ahead of the new command so the FIFO order holds either way.
	always @(posedge clk) begin
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done) begin
				deque_sb.check_result(deque_status_t'({ok, front_value, rear_value,
					is_empty, is_full, entry_count}));
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				deque_sb.write_capacity(capacity);
				moved = 1'b1;
			end
			if (start && !busy) begin
				deque_sb.take_command(opcode, value);
				moved = 1'b1;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("No transfer for %0d cycles", STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// One command transfer; start stays high on return so a burst keeps going.
	task automatic send_cmd(input logic [2:0] op, input logic [bdeq_pkg::WORD_W-1:0] word);
		start  <= 1'b1;
		opcode <= op;
		value  <= word;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Sender pause until every outstanding result is back, plus the latency.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (deque_sb.expected_status.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// Capacity is only changed with the block idle.
	task automatic set_capacity(input logic [bdeq_pkg::CNT_W-1:0] cap);
		drain();
		cfg_valid <= 1'b1;
		capacity  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly full-range words, with the sign and all-ones corners mixed in.
	function automatic logic [bdeq_pkg::WORD_W-1:0] random_word();
		case ($urandom_range(0, 11))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// ins_pct steers the fill level: high fills toward full, low drains.
	function automatic logic [2:0] pick_op(input int unsigned ins_pct);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			return ($urandom_range(0, 1) != 0) ? bdeq_pkg::OP_INS_FRONT
				: bdeq_pkg::OP_INS_REAR;
		if (roll < 96)
			return ($urandom_range(0, 1) != 0) ? bdeq_pkg::OP_REM_FRONT
				: bdeq_pkg::OP_REM_REAR;
		if ($urandom_range(0, 1) != 0)
			return bdeq_pkg::OP_QUERY;
		return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
	endfunction

	initial begin
		int unsigned      phase_cap     [N_PHASES];
		int unsigned      phase_len     [N_PHASES];
		int unsigned      phase_ins_pct [N_PHASES];
		int unsigned      burst_left;
		logic             all_good;

		// Phase plan. The first fill runs with capacity above the store depth,
		// so the count has to saturate at the depth; the next phase then drops
		// capacity far below the count, leaving the deque over-full.
		phase_cap     = '{511, 5, 256, 3, 0, 1, 0, 257};
		phase_len     = '{300, 40, 40, 30, 15, 20, 40, 20};
		phase_ins_pct = '{95, 30, 50, 55, 50, 50, 60, 50};
		phase_cap[6]  = $urandom_range(1, 300);

		arst_n    <= 1'b0;
		start     <= 1'b0;
		opcode    <= bdeq_pkg::OP_QUERY;
		value     <= '0;
		cfg_valid <= 1'b0;
		capacity  <= bdeq_pkg::CAP_MAX;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-queue behavior at reset capacity.
		send_cmd(bdeq_pkg::OP_QUERY, 32'h1234_5678);
		send_cmd(bdeq_pkg::OP_REM_FRONT, '0);
		send_cmd(bdeq_pkg::OP_REM_REAR, '0);
		// Word extremes at both ends, front index wrapping below zero.
		send_cmd(bdeq_pkg::OP_INS_FRONT, 32'h7fff_ffff);
		send_cmd(bdeq_pkg::OP_INS_REAR, 32'h8000_0000);
		send_cmd(bdeq_pkg::OP_INS_FRONT, 32'hffff_ffff);
		send_cmd(bdeq_pkg::OP_INS_REAR, 32'h0000_0000);
		send_cmd(bdeq_pkg::OP_QUERY, '0);
		// Unused opcodes: refused, deque untouched, value ignored.
		send_cmd(OP_UNUSED_LO, 32'hdead_beef);
		send_cmd(OP_UNUSED_LO + 3'd1, 32'hffff_ffff);
		send_cmd(OP_UNUSED_HI, 32'h5555_aaaa);
		send_cmd(bdeq_pkg::OP_REM_FRONT, '0);
		send_cmd(bdeq_pkg::OP_REM_REAR, '0);
		send_cmd(bdeq_pkg::OP_QUERY, '0);

		// Capacity one, written with two entries held: over-full, inserts
		// refused, removals still work, no clearing on the write.
		set_capacity(bdeq_pkg::CNT_W'(1));
		send_cmd(bdeq_pkg::OP_INS_REAR, 32'h0bad_cafe);
		send_cmd(bdeq_pkg::OP_REM_REAR, '0);
		send_cmd(bdeq_pkg::OP_INS_FRONT, 32'h0bad_cafe);
		send_cmd(bdeq_pkg::OP_REM_FRONT, '0);
		send_cmd(bdeq_pkg::OP_INS_FRONT, 32'h0000_0005);

		// Capacity zero: once emptied, both empty and full stay set.
		set_capacity(bdeq_pkg::CNT_W'(0));
		send_cmd(bdeq_pkg::OP_REM_FRONT, '0);
		send_cmd(bdeq_pkg::OP_INS_REAR, 32'h8000_0000);
		send_cmd(bdeq_pkg::OP_INS_FRONT, 32'h7fff_ffff);
		send_cmd(bdeq_pkg::OP_QUERY, '0);

		// Random phases: bursts of random length with random gaps, each phase
		// opening with an idle capacity write, so the sender always waits out
		// every outstanding result at least once per phase.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_capacity(bdeq_pkg::CNT_W'(phase_cap[ph]));
			burst_left = 0;
			for (int i = 0; i < phase_len[ph]; i++) begin
				if (burst_left == 0) begin
					hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				send_cmd(pick_op(phase_ins_pct[ph]), random_word());
			end
		end

		drain();
		repeat (3) @(posedge clk);

		$display("Ran %0d commands (%0d refused) over %0d capacity settings,",
			deque_sb.commands, deque_sb.refused, deque_sb.cap_writes);
		$display("peak fill %0d entries; %0d bad results, %0d unexpected, %0d missing.",
			deque_sb.peak_held, deque_sb.mismatches, deque_sb.strays,
			deque_sb.expected_status.size());
		all_good = (deque_sb.mismatches == 0) && (deque_sb.strays == 0)
			&& (deque_sb.expected_status.size() == 0);
		if (all_good) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
